// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/sle_pkg.sv =====
package sle_pkg;

   localparam int unsigned LINE_LIMIT = 39;
   localparam int unsigned HEAD_BYTES = 12;
   localparam int unsigned POS_W      = $clog2(LINE_LIMIT + 1);
   localparam int unsigned HEAD_IDX_W = $clog2(HEAD_BYTES);
   localparam int unsigned KW_COUNT   = 8;
   localparam int unsigned KW_MAX     = 9;
   localparam int unsigned KW_OFFSET  = 3;

   localparam logic [7:0] END_MARK  = 8'hFF;
   localparam logic [7:0] NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_TWO  = 8'h32;
   localparam logic [7:0] CHAR_SEMI = 8'h3B;

   typedef enum logic [3:0] {
      EV_NONE  = 4'd0,
      EV_BCONN = 4'd1,
      EV_RUN   = 4'd2,
      EV_BHUP  = 4'd3,
      EV_DCONN = 4'd4,
      EV_DHUP  = 4'd5,
      EV_CINF  = 4'd6,
      EV_ICALL = 4'd7,
      EV_NODCH = 4'd8
   } event_type;

   // keywords in priority order, zero padded
   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX] = '{
      '{"B", "C", "O", "N", "_", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"T", "E", "I", " ", "O", "K",   8'h00, 8'h00, 8'h00},
      '{"B", "D", "I", "S", "_", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"D", "C", "O", "N", "_", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"D", "D", "I", "S", "_", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"C", "I", "F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"D", "C", "A", "L", "_", "I",   8'h00, 8'h00, 8'h00},
      '{"N", "O", " ", "D", "-", "C",   "H",   "A",   "N"}
   };
   localparam int unsigned KW_LEN [KW_COUNT] = '{5, 6, 5, 5, 5, 3, 6, 9};
   localparam event_type KW_EVENT [KW_COUNT] = '{
      EV_BCONN, EV_RUN, EV_BHUP, EV_DCONN, EV_DHUP, EV_CINF, EV_ICALL, EV_NODCH
   };

endpackage

// ===== hdl/status_line_event_classifier.sv =====
// Status line event classifier.
// req_ channel: one status byte per beat (req_valid / req_stall). 0xFF ends a line.
// rsp_ channel: one result beat per request beat: the echoed byte (0xFF shown as
//   newline), an event code, the channel (digit minus one) and both B-channel
//   active flags as they stand after this byte.
// Two register stages: an accepted beat waits in the input register and is
//   shown on rsp_ once it has moved into the result register. Throughput is
//   one beat per cycle while rsp_stall is low; every keyword is compared in
//   parallel against the registered twelve-byte line head in the single stage
//   between the input register and the result register.
// Reset (synchronous, active high) empties both stages, returns the line
//   position to zero and clears both B-channel flags. Head bytes are not
//   cleared; they are only looked at below the current line length.
// When the receiver stalls, the result register holds its beat; an empty input
//   register still takes one more beat. With both registers full, req_stall
//   follows rsp_stall in the same cycle, so nothing is lost or repeated.
`include "assert_macros.svh"

module status_line_event_classifier (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_status_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_echo_char,
   output logic [3:0]        rsp_event_code,
   output logic signed [1:0] rsp_event_channel,
   output logic              rsp_b1_active,
   output logic              rsp_b2_active
);
   import sle_pkg::*;

   // input register
   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   // result register
   logic             rsp_valid_ff;
   logic [7:0]       echo_ff;
   event_type        event_ff;
   logic [1:0]       chan_ff;
   // line state
   logic [7:0]       head_ff [HEAD_BYTES];
   logic [POS_W-1:0] pos_ff;
   logic             b1_ff;
   logic             b2_ff;

   logic             advance;   // input register moves into result register
   logic             in_ready;
   logic             line_end;
   logic             prefix_ok;
   logic [1:0]       digit;
   logic [7:0]       echo_in;
   event_type        event_in;
   logic [1:0]       chan_in;
   logic [POS_W-1:0] pos_in;
   logic             b1_in;
   logic             b2_in;

   // Result register frees up when empty or when its beat is taken this cycle.
   assign advance  = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign in_ready = !in_valid_ff || advance;
   assign req_stall = !in_ready;

   assign line_end = (in_byte_ff == END_MARK);
   assign digit    = in_byte_ff == END_MARK ? head_ff[1][1:0] : head_ff[1][1:0];

   // Line prefix "0<digit 0..2>;" needs at least three bytes in the line.
   assign prefix_ok = (pos_ff >= POS_W'(KW_OFFSET)) &&
                      (head_ff[0] == CHAR_ZERO) &&
                      (head_ff[1] >= CHAR_ZERO) && (head_ff[1] <= CHAR_TWO) &&
                      (head_ff[2] == CHAR_SEMI);

   always_comb begin
      logic kw_hit;
      kw_hit   = 1'b0;
      echo_in  = line_end ? NEWLINE : in_byte_ff;
      event_in = EV_NONE;
      chan_in  = 2'd0;
      pos_in   = pos_ff;
      b1_in    = b1_ff;
      b2_in    = b2_ff;
      if (line_end) begin
         pos_in = '0;
         if (prefix_ok) begin
            // walk from lowest priority up so the first keyword in order wins
            for (int k = KW_COUNT - 1; k >= 0; k--) begin
               kw_hit = (pos_ff >= POS_W'(KW_OFFSET + KW_LEN[k]));
               for (int i = 0; i < KW_MAX; i++) begin
                  if (i < KW_LEN[k] && head_ff[KW_OFFSET + i] != KW_TEXT[k][i]) begin
                     kw_hit = 1'b0;
                  end
               end
               if (kw_hit) begin
                  event_in = KW_EVENT[k];
               end
            end
            if (event_in != EV_NONE) begin
               chan_in = digit - 2'd1;   // digit zero reports -1
            end
            // B-channel connect / disconnect; channel zero leaves flags alone
            if (event_in == EV_BCONN || event_in == EV_BHUP) begin
               if (digit == 2'd1) begin
                  b1_in = (event_in == EV_BCONN);
               end
               if (digit == 2'd2) begin
                  b2_in = (event_in == EV_BCONN);
               end
            end
         end
      end else if (pos_ff < POS_W'(LINE_LIMIT)) begin
         pos_in = pos_ff + POS_W'(1);   // saturates at the line limit
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         b1_ff        <= 1'b0;
         b2_ff        <= 1'b0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            pos_ff       <= pos_in;
            b1_ff        <= b1_in;
            b2_ff        <= b2_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_ready && req_valid) begin
         in_byte_ff <= req_status_byte;
      end
      if (advance) begin
         echo_ff  <= echo_in;
         event_ff <= event_in;
         chan_ff  <= chan_in;
         // keep the head of the line; bytes past it are only counted
         if (!line_end && pos_ff < POS_W'(HEAD_BYTES)) begin
            head_ff[pos_ff[HEAD_IDX_W-1:0]] <= in_byte_ff;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_echo_char     = echo_ff;
   assign rsp_event_code    = event_ff;
   assign rsp_event_channel = chan_ff;
   // flags only move with the result register, so they match the beat on show
   assign rsp_b1_active     = b1_ff;
   assign rsp_b2_active     = b2_ff;

   `ASSERT_IMP(a_pos_saturates, clock, reset, 1'b1, pos_ff <= POS_W'(LINE_LIMIT))
   `ASSERT_IMP(a_event_on_line_end, clock, reset, rsp_valid && rsp_event_code != EV_NONE, rsp_echo_char == NEWLINE)
   `ASSERT_IMP(a_chan_needs_event, clock, reset, rsp_valid && rsp_event_channel != 2'sd0, rsp_event_code != EV_NONE)
   `ASSERT_NEXT(a_flags_only_on_end, clock, reset, !(advance && line_end), $stable(b1_ff) && $stable(b2_ff))
   `ASSERT_NEXT(a_pos_clears_on_end, clock, reset, advance && line_end, pos_ff == '0)

endmodule

// ===== test/sle_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the status line classifier, predicts each result
// beat from the request beats and compares field by field, oldest first.
module sle_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [7:0]        req_status_byte,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [7:0]        rsp_echo_char,
   input  logic [3:0]        rsp_event_code,
   input  logic signed [1:0] rsp_event_channel,
   input  logic              rsp_b1_active,
   input  logic              rsp_b2_active,
   output int                fail_count,
   output int                pending
);
   import sle_pkg::*;

   typedef struct packed {
      logic [7:0]        echo;
      event_type         code;
      logic signed [1:0] chan;
      logic              b1;
      logic              b2;
   } status_result_type;

   // keywords in priority order, matched from offset 3 of the line
   string keyword_text [8] = '{
      "BCON_", "TEI OK", "BDIS_", "DCON_", "DDIS_", "CIF", "DCAL_I", "NO D-CHAN"
   };

   logic [7:0]        line_head [12];
   logic [5:0]        line_pos = '0;
   logic              b1_on    = 1'b0;
   logic              b2_on    = 1'b0;
   status_result_type expected_q [$];
   int                errors   = 0;
   int                waiting  = 0;

   assign fail_count = errors;
   assign pending    = waiting;

   initial begin
      foreach (line_head[i]) line_head[i] = '0;
   end

   function automatic status_result_type classify_byte(input logic [7:0] c);
      status_result_type r;
      int unsigned       len;
      int unsigned       idx;
      logic [1:0]        digit;
      bit                hit;
      bit                ok;
      r.echo = (c == END_MARK) ? NEWLINE : c;
      r.code = EV_NONE;
      r.chan = 2'sd0;
      hit    = 1'b0;
      if (c == END_MARK) begin
         len      = line_pos;
         line_pos = '0;
         if (len > 2 && line_head[0] == "0" && line_head[1] >= "0" &&
             line_head[1] <= "2" && line_head[2] == ";") begin
            digit = 2'(line_head[1] - "0");
            for (int k = 0; k < 8; k++) begin
               if (!hit) begin
                  ok = 1'b1;
                  for (int i = 0; i < keyword_text[k].len(); i++) begin
                     idx = 3 + i;
                     if (idx >= len || idx >= 12 || line_head[idx] != keyword_text[k][i])
                        ok = 1'b0;
                  end
                  if (ok) begin
                     hit    = 1'b1;
                     r.code = event_type'(k + 1);
                     r.chan = 2'(int'(digit) - 1);
                  end
               end
            end
            if (r.code == EV_BCONN) begin
               if (digit == 2'd1) b1_on = 1'b1;
               if (digit == 2'd2) b2_on = 1'b1;
            end else if (r.code == EV_BHUP) begin
               if (digit == 2'd1) b1_on = 1'b0;
               if (digit == 2'd2) b2_on = 1'b0;
            end
         end
      end else begin
         if (line_pos < 12) line_head[line_pos] = c;
         if (line_pos < 39) line_pos = line_pos + 1'b1;
      end
      r.b1 = b1_on;
      r.b2 = b2_on;
      return r;
   endfunction

   task automatic flag_mismatch(input string field, input logic [7:0] want,
                                input logic [7:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      status_result_type exp_beat;
      if (!reset) begin
         // response side first, so a stray beat never pairs with this edge's request
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result beat, expected none, actual echo %h",
                        $time, rsp_echo_char);
            end else begin
               exp_beat = expected_q.pop_front();
               if (rsp_echo_char !== exp_beat.echo)
                  flag_mismatch("echo_char", exp_beat.echo, rsp_echo_char);
               if (rsp_event_code !== exp_beat.code)
                  flag_mismatch("event_code", 8'(exp_beat.code), 8'(rsp_event_code));
               if (rsp_event_channel !== exp_beat.chan)
                  flag_mismatch("event_channel", 8'(exp_beat.chan), 8'(rsp_event_channel));
               if (rsp_b1_active !== exp_beat.b1)
                  flag_mismatch("b1_active", 8'(exp_beat.b1), 8'(rsp_b1_active));
               if (rsp_b2_active !== exp_beat.b2)
                  flag_mismatch("b2_active", 8'(exp_beat.b2), 8'(rsp_b2_active));
            end
         end
         if (req_valid && !req_stall)
            expected_q.push_back(classify_byte(req_status_byte));
         waiting <= expected_q.size();
      end
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the status line classifier. The checker beside
// the block does all prediction; this module only makes beats and idles.
module tb_top;
   import sle_pkg::*;

   localparam int TOTAL_BEATS = 1700;

   logic              clock           = 1'b0;
   logic              reset           = 1'b1;
   logic              req_valid       = 1'b0;
   logic              req_stall;
   logic [7:0]        req_status_byte = '0;
   logic              rsp_valid;
   logic              rsp_stall       = 1'b0;
   logic [7:0]        rsp_echo_char;
   logic [3:0]        rsp_event_code;
   logic signed [1:0] rsp_event_channel;
   logic              rsp_b1_active;
   logic              rsp_b2_active;
   int                fail_count;
   int                pending;

   // idle odds in percent, changed per phase
   int send_idle_pct = 32;
   int recv_idle_pct = 59;
   int beats_sent    = 0;

   // same keyword set the card sends, priority order
   string keywords [8] = '{
      "BCON_", "TEI OK", "BDIS_", "DCON_", "DDIS_", "CIF", "DCAL_I", "NO D-CHAN"
   };

   always #5 clock = ~clock;

   status_line_event_classifier uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_status_byte   (req_status_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_echo_char     (rsp_echo_char),
      .rsp_event_code    (rsp_event_code),
      .rsp_event_channel (rsp_event_channel),
      .rsp_b1_active     (rsp_b1_active),
      .rsp_b2_active     (rsp_b2_active)
   );

   sle_checker chk (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_status_byte   (req_status_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_echo_char     (rsp_echo_char),
      .rsp_event_code    (rsp_event_code),
      .rsp_event_channel (rsp_event_channel),
      .rsp_b1_active     (rsp_b1_active),
      .rsp_b2_active     (rsp_b2_active),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // One request beat. Valid only drops when an idle gap is drawn, so a
   // back-to-back beat never sees valid lowered and raised in one step.
   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_status_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_line(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
      send_byte(END_MARK);
   endtask

   // hold the sender off until the checker has nothing outstanding
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [7:0]  line_q [$];
      string       kw;
      int          cut;
      int          phase;
      int          phase_now;
      int unsigned roll;

      phase = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: connect on channel 2, channel digit zero, empty line,
      // extreme bytes on a line without prefix, keyword cut short by the line end
      send_line("02;BCON_");
      send_line("00;CIF");
      send_byte(END_MARK);
      send_byte(8'h00);
      send_byte(8'hFE);
      send_byte(END_MARK);
      send_line("01;BDIS");

      while (beats_sent < TOTAL_BEATS) begin
         // phase change: sender idles more than receiver, then neither idles
         phase_now = beats_sent * 3 / TOTAL_BEATS;
         if (phase_now > 2) phase_now = 2;
         if (phase_now != phase) begin
            phase = phase_now;
            wait_drained();
            send_idle_pct = (phase == 1) ? 59 : 0;
            recv_idle_pct = (phase == 1) ? 32 : 0;
         end

         line_q.delete();
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            // well-formed status line with the odd corrupted prefix byte
            line_q.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 254))
                                                           : 8'("0"));
            line_q.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 254))
                                                          : 8'("0" + $urandom_range(0, 2)));
            line_q.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 254))
                                                           : 8'(";"));
            kw  = keywords[$urandom_range(0, 7)];
            cut = kw.len();
            if ($urandom_range(0, 4) == 0) cut = $urandom_range(0, kw.len() - 1);
            for (int i = 0; i < cut; i++) line_q.push_back(kw[i]);
            // trailing numbers or junk, ignored by prefix matching
            repeat ($urandom_range(0, 6)) begin
               line_q.push_back($urandom_range(0, 1) ? 8'("0" + $urandom_range(0, 9))
                                                     : 8'($urandom_range(0, 254)));
            end
         end else if (roll < 85) begin
            // raw noise; an 0xFF in here simply ends the line early
            repeat ($urandom_range(0, 15)) line_q.push_back(8'($urandom_range(0, 255)));
         end else if (roll < 93) begin
            // overlong line: position saturates, head still decides
            if ($urandom_range(0, 1)) begin
               line_q.push_back("0");
               line_q.push_back(8'("0" + $urandom_range(1, 2)));
               line_q.push_back(";");
               kw = $urandom_range(0, 1) ? "BCON_" : "BDIS_";
               for (int i = 0; i < kw.len(); i++) line_q.push_back(kw[i]);
            end
            repeat ($urandom_range(30, 45)) line_q.push_back(8'($urandom_range(0, 254)));
         end
         // otherwise an empty line: just the end mark

         foreach (line_q[i]) send_byte(line_q[i]);
         send_byte(END_MARK);
      end

      wait_drained();
      // allow the two pipeline stages to show any stray beat
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // hang guard, far above the slowest legitimate run
   initial begin : watchdog
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/sle_pkg.sv
hdl/status_line_event_classifier.sv
test/sle_checker.sv
test/tb_top.sv
